// File: rtl/core/shhg_pkg.sv
// ----------------------------------------------------------------------------
// shhg_pkg: shared types and constants of the sine hill height generator
// Holds the field widths, the register indexes, the word handed along the
// divider cells and the full-period sine table built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none
package shhg_pkg;
	localparam int SQ_W        = 13;
	localparam int PH_W        = 16;
	localparam int HGT_W       = 16;
	localparam int IDX_W       = 2;
	localparam int MAX_SQUARES = 4096;
	localparam int SINE_BITS   = 10;
	localparam int SINE_SIZE   = 1 << SINE_BITS;

	localparam logic [IDX_W-1:0] REG_SQUARES_ACROSS = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_SQUARES_DOWN   = IDX_W'(1);

	typedef logic signed [15:0] sine_t;
	typedef sine_t sine_rom_t [SINE_SIZE];

	// word handed from one divider cell to the next
	typedef struct packed {
		logic            valid;
		logic            oor;
		logic [SQ_W-1:0] sq_x;
		logic [SQ_W-1:0] sq_z;
		logic [SQ_W-1:0] rem_x;
		logic [SQ_W-1:0] rem_z;
		logic [PH_W-1:0] ph_x;
		logic [PH_W-1:0] ph_z;
	} div_word_t;

	function automatic sine_rom_t build_sine();
		sine_rom_t   rom;
		logic [63:0] q, r, y, y2, a, b, c, s, mag;
		for (int i = 0; i < SINE_SIZE; i++) begin
			q = 64'((i >> (SINE_BITS - 2)) & 3);
			r = 64'(i & ((1 << (SINE_BITS - 2)) - 1));
			y = r << (18 - SINE_BITS);
			if (q == 64'd1 || q == 64'd3)
				y = 64'd65536 - y;
			y2  = (y * y) >> 16;
			a   = 64'd5223 - ((y2 * 64'd307) >> 16);
			b   = 64'd42334 - ((y2 * a) >> 16);
			c   = 64'd102944 - ((y2 * b) >> 16);
			s   = (y * c) >> 16;
			mag = (s * 64'd32767 + 64'd32768) >> 16;
			if (mag > 64'd32767)
				mag = 64'd32767;
			rom[i] = (q < 64'd2) ? sine_t'(mag[15:0]) : -sine_t'(mag[15:0]);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();
endpackage
`default_nettype wire

// File: rtl/core/shhg_if.sv
// ----------------------------------------------------------------------------
// shhg interfaces: vertex and height channels
// Valid/ready channels carrying one vertex word and one height word.
// ----------------------------------------------------------------------------
`default_nettype none
interface shhg_vtx_if;
	logic                     valid;
	logic                     ready;
	logic [shhg_pkg::SQ_W-1:0] vertex_x;
	logic [shhg_pkg::SQ_W-1:0] vertex_z;
	modport source (output valid, output vertex_x, output vertex_z, input ready);
	modport sink (input valid, input vertex_x, input vertex_z, output ready);
endinterface

interface shhg_hgt_if;
	logic                      valid;
	logic                      ready;
	logic [shhg_pkg::HGT_W-1:0] height;
	logic                      out_of_range;
	modport source (output valid, output height, output out_of_range, input ready);
	modport sink (input valid, input height, input out_of_range, output ready);
endinterface
`default_nettype wire

// File: rtl/core/shhg_div_cell.sv
// ----------------------------------------------------------------------------
// shhg_div_cell: one restoring division step for both axes
// Produces one phase bit per axis and hands the word to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module shhg_div_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire shhg_pkg::div_word_t d,
	output shhg_pkg::div_word_t      q
);
	import shhg_pkg::*;

	logic [SQ_W:0]   rx2, rz2;
	logic            gex, gez;
	div_word_t       nxt;

	always_comb begin
		rx2 = {d.rem_x, 1'b0};
		rz2 = {d.rem_z, 1'b0};
		gex = rx2 >= {1'b0, d.sq_x};
		gez = rz2 >= {1'b0, d.sq_z};
		nxt = d;
		nxt.rem_x = gex ? SQ_W'(rx2 - {1'b0, d.sq_x}) : SQ_W'(rx2);
		nxt.rem_z = gez ? SQ_W'(rz2 - {1'b0, d.sq_z}) : SQ_W'(rz2);
		nxt.ph_x  = {d.ph_x[PH_W-2:0], gex};
		nxt.ph_z  = {d.ph_z[PH_W-2:0], gez};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nxt;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/shhg_wave.sv
// ----------------------------------------------------------------------------
// shhg_wave: sine lookup, wave products and mix
// Turns the two phases into the clamped 16-bit height in five stages.
// ----------------------------------------------------------------------------
`default_nettype none
module shhg_wave (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire shhg_pkg::div_word_t d,
	output logic                     out_valid,
	output logic [shhg_pkg::HGT_W-1:0] out_height,
	output logic                     out_oor
);
	import shhg_pkg::*;

	logic [PH_W-1:0] px3, px11, pz3, pz11;
	logic [4:1]      v;
	logic            oor_s1, oor_s2, oor_s3, oor_s4;
	sine_t           bx_s1, bz_s1, dx_s1, dz_s1;
	logic signed [31:0] bp_s2, dp_s2;
	logic signed [16:0] broad, detail;
	logic signed [19:0] num;
	logic [17:0]     mag_s3;
	logic            neg_s3, neg_s4;
	logic [33:0]     prod_s4;
	logic [15:0]     quo;
	logic signed [17:0] hs;

	always_comb begin
		px3  = 16'(d.ph_x * 16'd3);
		px11 = 16'(d.ph_x * 16'd11);
		pz3  = 16'(d.ph_z * 16'd3);
		pz11 = 16'(d.ph_z * 16'd11);
		broad  = 17'(bp_s2 >>> 15);
		detail = 17'(dp_s2 >>> 15);
		num    = (20'(broad) <<< 2) + 20'(detail);
		// reciprocal of five, exact for magnitudes below 2^18
		quo = 16'(prod_s4 >> 18);
		hs  = (neg_s4 ? -18'(quo) : 18'(quo)) + 18'sd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v         <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			v         <= {v[3:1], d.valid};
			out_valid <= v[4];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s1  <= d.oor;
			bx_s1   <= SINE_ROM[px3[PH_W-1 -: SINE_BITS]];
			bz_s1   <= SINE_ROM[pz3[PH_W-1 -: SINE_BITS]];
			dx_s1   <= SINE_ROM[px11[PH_W-1 -: SINE_BITS]];
			dz_s1   <= SINE_ROM[pz11[PH_W-1 -: SINE_BITS]];
			oor_s2  <= oor_s1;
			bp_s2   <= bx_s1 * bz_s1;
			dp_s2   <= dx_s1 * dz_s1;
			oor_s3  <= oor_s2;
			neg_s3  <= num < 0;
			mag_s3  <= (num < 0) ? 18'(-num) : 18'(num);
			oor_s4  <= oor_s3;
			neg_s4  <= neg_s3;
			prod_s4 <= mag_s3 * 34'd52429;
			out_oor <= oor_s4;
			if (oor_s4 || hs < 0)
				out_height <= '0;
			else if (hs > 18'sd65535)
				out_height <= '1;
			else
				out_height <= HGT_W'(hs);
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/sine_hill_height_generator.sv
// ----------------------------------------------------------------------------
// sine_hill_height_generator: height of one grid vertex per word
// Phase division in a row of cells, then sine lookup, products and mix.
// ----------------------------------------------------------------------------
// Usage:
//   vtx carries one vertex word (vertex_x, vertex_z); hgt returns one word
//   (height, out_of_range) per vertex, in order.
//   cfg_we/cfg_index/cfg_data write squares_across (index 0) or
//   squares_down (index 1); zero stores 1, values above 4096 store 4096.
//   Write them only while no vertex is in flight.
// Timing:
//   the path is 16 divider cells, one quotient bit each, then four wave
//   stages and the output register. A new vertex is taken every cycle
//   unless hgt stalls. When hgt stalls with a word held, the whole
//   pipeline holds, empty slots included, and vtx.ready drops; with no word held everything advances.
// Reset:
//   all pipeline slots empty, both grid sizes return to 64.
// ----------------------------------------------------------------------------
`default_nettype none
module sine_hill_height_generator (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [shhg_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [shhg_pkg::SQ_W-1:0]  cfg_data,
	shhg_vtx_if.sink                       vtx,
	shhg_hgt_if.source                     hgt
);
	import shhg_pkg::*;

	localparam int CELLS = PH_W;

	logic [SQ_W-1:0] sq_x_q, sq_z_q, lim;
	logic            en;
	div_word_t       w_in;
	div_word_t       w [CELLS+1];

	assign lim = (cfg_data == '0) ? SQ_W'(1) :
		(cfg_data > SQ_W'(MAX_SQUARES)) ? SQ_W'(MAX_SQUARES) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_x_q <= SQ_W'(64);
			sq_z_q <= SQ_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SQUARES_ACROSS: sq_x_q <= lim;
				REG_SQUARES_DOWN:   sq_z_q <= lim;
				default: ;
			endcase
		end
	end

	assign en = !hgt.valid || hgt.ready;
	assign vtx.ready = en;

	// vertex on the grid edge wraps to phase zero
	always_comb begin
		w_in.valid = vtx.valid;
		w_in.oor   = (vtx.vertex_x > sq_x_q) || (vtx.vertex_z > sq_z_q);
		w_in.sq_x  = sq_x_q;
		w_in.sq_z  = sq_z_q;
		w_in.rem_x = (vtx.vertex_x >= sq_x_q) ? '0 : vtx.vertex_x;
		w_in.rem_z = (vtx.vertex_z >= sq_z_q) ? '0 : vtx.vertex_z;
		w_in.ph_x  = '0;
		w_in.ph_z  = '0;
	end

	assign w[0] = w_in;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		shhg_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (w[i]),
			.q      (w[i+1])
		);
	end

	shhg_wave u_wave (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.d          (w[CELLS]),
		.out_valid  (hgt.valid),
		.out_height (hgt.height),
		.out_oor    (hgt.out_of_range)
	);
endmodule
`default_nettype wire
